// ===== design/cpseg_pkg.sv =====
package cpseg_pkg;

  localparam int unsigned COORD_BITS  = 16;
  localparam int unsigned DIFF_BITS   = COORD_BITS + 1;
  localparam int unsigned PROD_BITS   = 2 * COORD_BITS + 1;
  localparam int unsigned NUM_BITS    = 2 * COORD_BITS + 3;
  localparam int unsigned DEN_BITS    = 2 * COORD_BITS + 2;
  localparam int unsigned SCALED_BITS = 3 * COORD_BITS + 2;
  localparam int unsigned NUM_AXES    = 3;
  localparam int unsigned NUM_REGS    = 6;
  localparam int unsigned REG_IDX_BITS = $clog2(NUM_REGS);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic        [COORD_BITS-1:0] mag_t;
  typedef logic        [REG_IDX_BITS-1:0] reg_idx_t;

  localparam reg_idx_t REG_START_X = reg_idx_t'(0);
  localparam reg_idx_t REG_START_Y = reg_idx_t'(1);
  localparam reg_idx_t REG_START_Z = reg_idx_t'(2);
  localparam reg_idx_t REG_END_X   = reg_idx_t'(3);
  localparam reg_idx_t REG_END_Y   = reg_idx_t'(4);
  localparam reg_idx_t REG_END_Z   = reg_idx_t'(5);

  typedef enum logic [1:0] {
    WHERE_INTERIOR = 2'd0,
    WHERE_START    = 2'd1,
    WHERE_END      = 2'd2,
    WHERE_DEGEN    = 2'd3
  } where_e;

  typedef struct packed {
    coord_t query_x;
    coord_t query_y;
    coord_t query_z;
  } in_t;

  typedef struct packed {
    coord_t near_x;
    coord_t near_y;
    coord_t near_z;
    where_e where_code;
  } out_t;

  typedef struct packed {
    logic signed [NUM_BITS-1:0] num;
    logic        [DEN_BITS-1:0] den;
  } dot_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][SCALED_BITS-1:0] prod;
    logic [DEN_BITS-1:0]                  den;
    where_e                               code;
  } scaled_t;

  typedef struct packed {
    logic [NUM_AXES-1:0][COORD_BITS-1:0] off;
    where_e                              code;
  } quot_t;

endpackage

// ===== design/cpseg_dot.sv =====
module cpseg_dot (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cpseg_pkg::coord_t start_i [3],
  input  cpseg_pkg::diff_t  diff_i  [3],
  input  cpseg_pkg::mag_t   dmag_i  [3],
  input  logic             valid_i,
  output logic             ready_o,
  input  cpseg_pkg::in_t    data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output cpseg_pkg::dot_t   data_o
);
  import cpseg_pkg::*;

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  coord_t qv [NUM_AXES];
  diff_t  vec_d [NUM_AXES];
  diff_t  vec_q [NUM_AXES];
  logic signed [PROD_BITS-1:0] pv_d [NUM_AXES];
  logic signed [PROD_BITS-1:0] pv_q [NUM_AXES];
  logic [2*COORD_BITS-1:0] sq_d [NUM_AXES];
  logic [2*COORD_BITS-1:0] sq_q [NUM_AXES];
  dot_t dot_d, dot_q;

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  assign qv[0] = data_i.query_x;
  assign qv[1] = data_i.query_y;
  assign qv[2] = data_i.query_z;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      vec_d[i] = {qv[i][COORD_BITS-1], qv[i]} - {start_i[i][COORD_BITS-1], start_i[i]};
      pv_d[i]  = PROD_BITS'(vec_q[i]) * PROD_BITS'(diff_i[i]);
      sq_d[i]  = (2*COORD_BITS)'(dmag_i[i]) * (2*COORD_BITS)'(dmag_i[i]);
    end
    dot_d.num = NUM_BITS'(pv_q[0]) + NUM_BITS'(pv_q[1]) + NUM_BITS'(pv_q[2]);
    dot_d.den = DEN_BITS'(sq_q[0]) + DEN_BITS'(sq_q[1]) + DEN_BITS'(sq_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) vec_q <= vec_d;
    if (rdy2 && v1_q) begin
      pv_q <= pv_d;
      sq_q <= sq_d;
    end
    if (rdy3 && v2_q) dot_q <= dot_d;
  end

  assign valid_o = v3_q;
  assign data_o  = dot_q;

endmodule

// ===== design/cpseg_scale.sv =====
module cpseg_scale (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cpseg_pkg::mag_t     dmag_i [3],
  input  logic               valid_i,
  output logic               ready_o,
  input  cpseg_pkg::dot_t     data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output cpseg_pkg::scaled_t  data_o
);
  import cpseg_pkg::*;

  logic v1_q, v2_q;
  logic rdy1, rdy2;
  where_e code_d, code_q;
  logic [DEN_BITS-1:0] numu;
  logic [DEN_BITS-1:0] den_q;
  logic [2*COORD_BITS-1:0] lo_d [NUM_AXES];
  logic [2*COORD_BITS-1:0] lo_q [NUM_AXES];
  logic [DEN_BITS-1:0]     hi_d [NUM_AXES];
  logic [DEN_BITS-1:0]     hi_q [NUM_AXES];
  scaled_t sc_d, sc_q;

  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  assign numu = data_i.num[DEN_BITS-1:0];

  always_comb begin
    priority if (data_i.den == '0) begin
      code_d = WHERE_DEGEN;
    end else if (data_i.num[NUM_BITS-1]) begin
      code_d = WHERE_START;
    end else if ($signed(data_i.num) > $signed({1'b0, data_i.den})) begin
      code_d = WHERE_END;
    end else begin
      code_d = WHERE_INTERIOR;
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      lo_d[i] = (2*COORD_BITS)'(numu[COORD_BITS-1:0]) * (2*COORD_BITS)'(dmag_i[i]);
      hi_d[i] = DEN_BITS'(numu[DEN_BITS-1:COORD_BITS]) * DEN_BITS'(dmag_i[i]);
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      sc_d.prod[i] = {hi_q[i], {COORD_BITS{1'b0}}} + SCALED_BITS'(lo_q[i]);
    end
    sc_d.den  = den_q;
    sc_d.code = code_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      lo_q   <= lo_d;
      hi_q   <= hi_d;
      den_q  <= data_i.den;
      code_q <= code_d;
    end
    if (rdy2 && v1_q) sc_q <= sc_d;
  end

  assign valid_o = v2_q;
  assign data_o  = sc_q;

endmodule

// ===== design/cpseg_div.sv =====
module cpseg_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  cpseg_pkg::scaled_t  data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output cpseg_pkg::quot_t    data_o
);
  import cpseg_pkg::*;

  localparam int unsigned STAGES = COORD_BITS;

  logic [STAGES:0] rdy;
  logic            vq     [STAGES];
  logic [SCALED_BITS-1:0] rem_q [STAGES][NUM_AXES];
  logic [COORD_BITS-1:0]  qt_q  [STAGES][NUM_AXES];
  logic [DEN_BITS-1:0]    den_q [STAGES];
  where_e                 code_q [STAGES];

  assign rdy[STAGES] = ready_i;
  assign ready_o     = rdy[0];

  // one quotient bit per stage, most significant first
  for (genvar j = 0; j < STAGES; j++) begin : g_stage
    localparam int unsigned SH = STAGES - 1 - j;

    logic                   sv;
    logic [SCALED_BITS-1:0] srem [NUM_AXES];
    logic [COORD_BITS-1:0]  sqt  [NUM_AXES];
    logic [DEN_BITS-1:0]    sden;
    where_e                 scode;
    logic [SCALED_BITS-1:0] dsh;
    logic [SCALED_BITS:0]   trial [NUM_AXES];
    logic [SCALED_BITS-1:0] nrem  [NUM_AXES];
    logic [COORD_BITS-1:0]  nqt   [NUM_AXES];

    if (j == 0) begin : g_first
      assign sv    = valid_i;
      assign sden  = data_i.den;
      assign scode = data_i.code;
      for (genvar l = 0; l < NUM_AXES; l++) begin : g_lane
        assign srem[l] = data_i.prod[l];
        assign sqt[l]  = '0;
      end
    end else begin : g_next
      assign sv    = vq[j-1];
      assign sden  = den_q[j-1];
      assign scode = code_q[j-1];
      for (genvar l = 0; l < NUM_AXES; l++) begin : g_lane
        assign srem[l] = rem_q[j-1][l];
        assign sqt[l]  = qt_q[j-1][l];
      end
    end

    assign rdy[j] = !vq[j] || rdy[j+1];
    assign dsh    = SCALED_BITS'(sden) << SH;

    always_comb begin
      for (int l = 0; l < NUM_AXES; l++) begin
        trial[l] = {1'b0, srem[l]} - {1'b0, dsh};
        if (trial[l][SCALED_BITS]) begin
          nrem[l] = srem[l];
          nqt[l]  = sqt[l];
        end else begin
          nrem[l] = trial[l][SCALED_BITS-1:0];
          nqt[l]  = sqt[l] | (COORD_BITS'(1) << SH);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vq[j] <= 1'b0;
      end else if (rdy[j]) begin
        vq[j] <= sv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[j] && sv) begin
        qt_q[j]   <= nqt;
        den_q[j]  <= sden;
        code_q[j] <= scode;
        rem_q[j]  <= nrem;
      end
    end
  end

  assign valid_o = vq[STAGES-1];
  always_comb begin
    for (int l = 0; l < NUM_AXES; l++) begin
      data_o.off[l] = qt_q[STAGES-1][l];
    end
    data_o.code = code_q[STAGES-1];
  end

endmodule

// ===== design/closest_point_on_segment_3d.sv =====
// Closest point on a 3D segment.
// Config: cfg_we_i/cfg_idx_i/cfg_data_i write the segment start (0..2) and
// end (3..5) coordinates; other indexes are ignored. Write only when idle.
// Request channel: in_valid_i/in_ready_o carry one query point per request.
// Response channel: out_valid_o/out_ready_i return the nearest point on the
// segment, its offset from the start truncated toward zero, and a code:
// interior, clamped to start, clamped to end or degenerate segment.
// Pipeline: three stages of dot products, two of split multiply, one
// restoring divider stage per quotient bit, one output register.
// Throughput: one request per cycle while the receiver takes responses,
// three divider lanes working side by side.
// Reset clears the config registers to zero and empties every stage.
// When the receiver stalls, each stage only holds if the one after it is
// full, so bubbles are squeezed out and in_ready_o falls only once the whole
// pipe is full.
module closest_point_on_segment_3d (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  cpseg_pkg::reg_idx_t      cfg_idx_i,
  input  cpseg_pkg::coord_t        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  cpseg_pkg::in_t           in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output cpseg_pkg::out_t          out_data_o
);
  import cpseg_pkg::*;

  coord_t start_q [NUM_AXES];
  coord_t end_q   [NUM_AXES];
  diff_t  diff_d  [NUM_AXES];
  diff_t  diff_q  [NUM_AXES];
  mag_t   dmag_d  [NUM_AXES];
  mag_t   dmag_q  [NUM_AXES];

  logic    dot_valid, dot_ready;
  dot_t    dot_data;
  logic    sc_valid, sc_ready;
  scaled_t sc_data;
  logic    div_valid, div_ready;
  quot_t   div_data;

  coord_t near_d [NUM_AXES];
  logic   out_valid_q;
  out_t   out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        start_q[i] <= '0;
        end_q[i]   <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_START_X: start_q[0] <= cfg_data_i;
        REG_START_Y: start_q[1] <= cfg_data_i;
        REG_START_Z: start_q[2] <= cfg_data_i;
        REG_END_X:   end_q[0]   <= cfg_data_i;
        REG_END_Y:   end_q[1]   <= cfg_data_i;
        REG_END_Z:   end_q[2]   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // segment direction and per-axis magnitude, registered from config registers
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      diff_d[i] = {end_q[i][COORD_BITS-1], end_q[i]} -
                  {start_q[i][COORD_BITS-1], start_q[i]};
      dmag_d[i] = diff_d[i][DIFF_BITS-1] ? COORD_BITS'(-diff_d[i])
                                         : diff_d[i][COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        diff_q[i] <= '0;
        dmag_q[i] <= '0;
      end
    end else begin
      diff_q <= diff_d;
      dmag_q <= dmag_d;
    end
  end

  cpseg_dot u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .diff_i  (diff_q),
    .dmag_i  (dmag_q),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (dot_valid),
    .ready_i (dot_ready),
    .data_o  (dot_data)
  );

  cpseg_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .dmag_i  (dmag_q),
    .valid_i (dot_valid),
    .ready_o (dot_ready),
    .data_i  (dot_data),
    .valid_o (sc_valid),
    .ready_i (sc_ready),
    .data_o  (sc_data)
  );

  cpseg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sc_valid),
    .ready_o (sc_ready),
    .data_i  (sc_data),
    .valid_o (div_valid),
    .ready_i (div_ready),
    .data_o  (div_data)
  );

  assign div_ready = !out_valid_q || out_ready_i;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      unique case (div_data.code)
        WHERE_INTERIOR: begin
          near_d[i] = diff_q[i][DIFF_BITS-1] ? start_q[i] - div_data.off[i]
                                             : start_q[i] + div_data.off[i];
        end
        WHERE_END:   near_d[i] = end_q[i];
        WHERE_START: near_d[i] = start_q[i];
        WHERE_DEGEN: near_d[i] = start_q[i];
        default:     near_d[i] = start_q[i];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (div_ready) begin
      out_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_ready && div_valid) begin
      out_q.near_x     <= near_d[0];
      out_q.near_y     <= near_d[1];
      out_q.near_z     <= near_d[2];
      out_q.where_code <= div_data.code;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/cpseg_checker.sv =====
module cpseg_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input cpseg_pkg::out_t  out_data_o
);
  import cpseg_pkg::*;

  // response held while the receiver stalls
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("response dropped or changed under stall");

  // nothing comes out straight after reset
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("response after reset");

  // requests are refused only when the pipe is full and the output is stalled
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("request refused while pipe can move");

  // a full, stalled pipe stays full: ready then follows the receiver only
  a_ready_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o && !out_ready_i |=> out_valid_o && (in_ready_o == out_ready_i))
    else $error("pipe lost a request under stall");

endmodule

bind closest_point_on_segment_3d cpseg_checker u_cpseg_checker (.*);
